// ===== rtl/avs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avs_pkg
// Shared widths, codes and beat structures for the voltage feedback step.
// ----------------------------------------------------------------------------
package avs_pkg;

  localparam int TEMP_W    = 19;
  localparam int VOLT_W    = 21;
  localparam int TARGET_W  = 10;
  localparam int DELAY_W   = 7;
  localparam int FAULT_W   = 3;
  localparam int STATUS_W  = 2;
  localparam int REG_IDX_W = 2;
  localparam int LANE_SIZE = 4;

  localparam logic [VOLT_W-1:0]        STEP_UV          = 21'd10000;
  localparam logic signed [TEMP_W-1:0] MAX_TEMP_MC      = 19'sd95000;
  localparam int                       HOLD_LOW_MARGIN  = 1;
  localparam int                       HOLD_HIGH_MARGIN = 10;
  localparam logic [DELAY_W-1:0]       STEP_DELAY_MS    = 7'd10;
  localparam logic [DELAY_W-1:0]       IDLE_DELAY_MS    = 7'd100;
  localparam logic [DELAY_W-1:0]       STOP_DELAY_MS    = 7'd0;

  localparam logic [VOLT_W-1:0] MIN_VOLT_RESET  = 21'd800000;
  localparam logic [VOLT_W-1:0] SAFE_VOLT_RESET = 21'd1300000;

  localparam logic [STATUS_W-1:0] ST_VALID  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;

  localparam logic [FAULT_W-1:0] FLT_NONE      = 3'd0;
  localparam logic [FAULT_W-1:0] FLT_READ_ERR  = 3'd1;
  localparam logic [FAULT_W-1:0] FLT_OVER_TEMP = 3'd2;
  localparam logic [FAULT_W-1:0] FLT_WINDOW    = 3'd3;
  localparam logic [FAULT_W-1:0] FLT_ZERO_AVG  = 3'd4;

  localparam logic [REG_IDX_W-1:0] REG_PERF_TARGET = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_VOLT    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SAFE_VOLT   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_LOOP_ARM    = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [TEMP_W-1:0] temp;
    logic [VOLT_W-1:0]        volt;
  } tick_ctl_t;

  typedef struct packed {
    logic                run;
    logic [FAULT_W-1:0]  fault;
    logic [DELAY_W-1:0]  delay;
    logic                write;
    logic [VOLT_W-1:0]   req;
  } step_res_t;

endpackage

// ===== rtl/avs_voltage_feedback_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avs_voltage_feedback_step
// Adaptive voltage scaling loop tick: averages monitor records and picks
// the next regulator request.
// Each input beat passes through the lane sum register, then the output
// register. Throughput: one beat per cycle while m_tready does not stall.
// Reset: rst clears pipeline valids and the running flag, and loads the
// configuration registers with their defaults.
// ----------------------------------------------------------------------------
module avs_voltage_feedback_step import avs_pkg::*; #(
  parameter int SAMPLE_COUNT = 8,
  parameter int SAMPLE_BITS  = 10,
  localparam int IN_BITS  = TEMP_W + VOLT_W + SAMPLE_COUNT * SAMPLE_BITS,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = VOLT_W + 1 + DELAY_W + FAULT_W + 1 + SAMPLE_BITS,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_addr,
  input  logic [VOLT_W-1:0]    wr_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // temperature_mc, measured_voltage_uv, hpm_sample_0 .. hpm_sample_N-1
  input  logic [IN_W-1:0]      s_tdata,
  // temp_status
  input  logic [STATUS_W-1:0]  s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // voltage_request_uv, write_voltage, next_delay_ms, fault_code,
  // loop_running, hpm_average
  output logic [OUT_W-1:0]     m_tdata
);

  localparam int NUM_LANES = (SAMPLE_COUNT + LANE_SIZE - 1) / LANE_SIZE;
  localparam int PAD_W     = NUM_LANES * LANE_SIZE * SAMPLE_BITS;
  localparam int PS_W      = SAMPLE_BITS + $clog2(LANE_SIZE);

  logic [TARGET_W-1:0]    perf_target;
  logic [VOLT_W-1:0]      min_voltage_uv;
  logic [VOLT_W-1:0]      safe_voltage_uv;
  logic                   running;

  logic                   s1_valid;
  tick_ctl_t              s1_ctl;
  logic [PS_W-1:0]        psum [NUM_LANES];
  logic [PAD_W-1:0]       samp_pad;
  logic                   load1;
  logic                   load2;

  step_res_t              res_next;
  logic [SAMPLE_BITS-1:0] avg_next;
  step_res_t              res;
  logic [SAMPLE_BITS-1:0] avg;

  assign load2    = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || load2;
  assign load1    = s_tvalid && s_tready;
  assign samp_pad = PAD_W'(s_tdata[IN_BITS-1:TEMP_W+VOLT_W]);

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    avs_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .clk    (clk),
      .en     (load1),
      .samples(samp_pad[g*LANE_SIZE*SAMPLE_BITS +: LANE_SIZE*SAMPLE_BITS]),
      .psum   (psum[g])
    );
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_ctl.status <= s_tuser;
      s1_ctl.temp   <= s_tdata[TEMP_W-1:0];
      s1_ctl.volt   <= s_tdata[TEMP_W+VOLT_W-1:TEMP_W];
    end
  end

  avs_merge #(
    .SAMPLE_COUNT(SAMPLE_COUNT),
    .SAMPLE_BITS (SAMPLE_BITS),
    .NUM_LANES   (NUM_LANES)
  ) u_merge (
    .psum           (psum),
    .ctl            (s1_ctl),
    .running        (running),
    .perf_target    (perf_target),
    .min_voltage_uv (min_voltage_uv),
    .safe_voltage_uv(safe_voltage_uv),
    .res            (res_next),
    .hpm_average    (avg_next)
  );

  always_ff @(posedge clk) begin
    if (load2) begin
      res <= res_next;
      avg <= avg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (load1) begin
        s1_valid <= 1'b1;
      end else if (load2) begin
        s1_valid <= 1'b0;
      end
      if (load2) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      perf_target     <= '0;
      min_voltage_uv  <= MIN_VOLT_RESET;
      safe_voltage_uv <= SAFE_VOLT_RESET;
      running         <= 1'b0;
    end else begin
      if (wr_en) begin
        case (wr_addr)
          REG_PERF_TARGET: perf_target     <= wr_data[TARGET_W-1:0];
          REG_MIN_VOLT:    min_voltage_uv  <= wr_data;
          REG_SAFE_VOLT:   safe_voltage_uv <= wr_data;
          REG_LOOP_ARM:    running         <= wr_data[0];
          default: ;
        endcase
      end
      if (load2 && !(wr_en && wr_addr == REG_LOOP_ARM)) begin
        running <= res_next.run;
      end
    end
  end

  assign m_tdata = OUT_W'({avg, res.run, res.fault, res.delay, res.write, res.req});

endmodule

// ===== rtl/avs_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avs_lane
// One summing lane: adds a group of monitor records and registers the sum.
// ----------------------------------------------------------------------------
module avs_lane import avs_pkg::*; #(
  parameter int SAMPLE_BITS = 10,
  localparam int PS_W = SAMPLE_BITS + $clog2(LANE_SIZE)
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [LANE_SIZE*SAMPLE_BITS-1:0] samples,
  output logic [PS_W-1:0]                  psum
);

  logic [PS_W-1:0] acc;

  always_comb begin
    acc = '0;
    for (int i = 0; i < LANE_SIZE; i++) begin
      acc = acc + PS_W'(samples[i*SAMPLE_BITS +: SAMPLE_BITS]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      psum <= acc;
    end
  end

endmodule

// ===== rtl/avs_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avs_merge
// Combines lane sums into the average and decides the voltage step.
// ----------------------------------------------------------------------------
module avs_merge import avs_pkg::*; #(
  parameter int SAMPLE_COUNT = 8,
  parameter int SAMPLE_BITS  = 10,
  parameter int NUM_LANES    = 2,
  localparam int PS_W = SAMPLE_BITS + $clog2(LANE_SIZE)
) (
  input  logic [PS_W-1:0]        psum [NUM_LANES],
  input  tick_ctl_t              ctl,
  input  logic                   running,
  input  logic [TARGET_W-1:0]    perf_target,
  input  logic [VOLT_W-1:0]      min_voltage_uv,
  input  logic [VOLT_W-1:0]      safe_voltage_uv,
  output step_res_t              res,
  output logic [SAMPLE_BITS-1:0] hpm_average
);

  localparam int SUM_W  = SAMPLE_BITS + $clog2(SAMPLE_COUNT);
  localparam int CMP_W  = ((SAMPLE_BITS > TARGET_W) ? SAMPLE_BITS : TARGET_W) + 1;
  // divide by SAMPLE_COUNT: rounded-up reciprocal, exact over the whole sum range
  localparam int SH_W   = SUM_W + $clog2(SAMPLE_COUNT);
  localparam int RECIP  = ((1 << SH_W) + SAMPLE_COUNT - 1) / SAMPLE_COUNT;
  localparam int PROD_W = 2 * SUM_W + 1;

  logic [SUM_W-1:0]       sum;
  logic [PROD_W-1:0]      prod;
  logic [SAMPLE_BITS-1:0] avg;
  logic [CMP_W-1:0]       lo_lim;
  logic [CMP_W-1:0]       hi_lim;
  logic [VOLT_W:0]        up;
  logic [VOLT_W-1:0]      up_cl;
  logic [VOLT_W-1:0]      dn;
  logic [VOLT_W-1:0]      dn_cl;
  logic [VOLT_W-1:0]      next;
  logic [DELAY_W-1:0]     dly;

  always_comb begin
    sum = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      sum = sum + SUM_W'(psum[i]);
    end
    prod   = PROD_W'(sum) * PROD_W'(RECIP);
    avg    = prod[SH_W +: SAMPLE_BITS];
    lo_lim = CMP_W'(perf_target) + CMP_W'(HOLD_LOW_MARGIN);
    hi_lim = CMP_W'(perf_target) + CMP_W'(HOLD_HIGH_MARGIN);

    up    = {1'b0, ctl.volt} + {1'b0, STEP_UV};
    up_cl = (up > {1'b0, safe_voltage_uv}) ? safe_voltage_uv : up[VOLT_W-1:0];
    dn    = (ctl.volt >= STEP_UV) ? (ctl.volt - STEP_UV) : '0;
    dn_cl = (dn < min_voltage_uv) ? min_voltage_uv : dn;

    if (CMP_W'(avg) <= lo_lim) begin
      next = up_cl;
      dly  = STEP_DELAY_MS;
    end else if (CMP_W'(avg) >= hi_lim) begin
      next = dn_cl;
      dly  = STEP_DELAY_MS;
    end else begin
      next = ctl.volt;
      dly  = IDLE_DELAY_MS;
    end

    res.req     = ctl.volt;
    res.write   = 1'b0;
    res.delay   = STOP_DELAY_MS;
    res.fault   = FLT_NONE;
    res.run     = 1'b0;
    hpm_average = '0;

    if (!running) begin
      res.run = 1'b0;
    end else if (ctl.status == ST_ABSENT) begin
      res.delay = IDLE_DELAY_MS;
      res.run   = 1'b1;
    end else if (ctl.status != ST_VALID) begin
      res.req   = safe_voltage_uv;
      res.write = 1'b1;
      res.fault = FLT_READ_ERR;
    end else if (ctl.temp >= MAX_TEMP_MC) begin
      res.req   = safe_voltage_uv;
      res.write = 1'b1;
      res.fault = FLT_OVER_TEMP;
    end else if (ctl.volt < min_voltage_uv || ctl.volt > safe_voltage_uv) begin
      res.req   = safe_voltage_uv;
      res.write = 1'b1;
      res.fault = FLT_WINDOW;
    end else if (avg == '0) begin
      res.req   = safe_voltage_uv;
      res.write = 1'b1;
      res.fault = FLT_ZERO_AVG;
    end else begin
      res.req     = next;
      res.write   = (next != ctl.volt);
      res.delay   = dly;
      res.run     = 1'b1;
      hpm_average = avg;
    end
  end

endmodule

// ===== tb/avs_voltage_feedback_step_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avs_voltage_feedback_step_test
// Self-checking bench for the voltage feedback step. Ticks are queued by a
// sequencer, driven onto the input stream and predicted as they are taken.
// Result beats are matched field by field against the predictions, in order,
// under several sender/receiver throttling patterns and one long hold-off.
// ----------------------------------------------------------------------------
module avs_voltage_feedback_step_test import avs_pkg::*; ();

  localparam int HPM_N       = 8;
  localparam int HPM_W       = 10;
  localparam int TICK_BITS   = TEMP_W + VOLT_W + HPM_N * HPM_W;
  localparam int TICK_W      = ((TICK_BITS + 7) / 8) * 8;
  localparam int FB_BITS     = VOLT_W + 1 + DELAY_W + FAULT_W + 1 + HPM_W;
  localparam int FB_W        = ((FB_BITS + 7) / 8) * 8;
  localparam int WATCHDOG    = 3000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASES      = 40;
  localparam int PHASE_TICKS = 20;

  localparam logic [STATUS_W-1:0] ST_READ_ERR = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0]         status;
    logic [HPM_N-1:0][HPM_W-1:0] hpm;
    logic [VOLT_W-1:0]           volt;
    logic signed [TEMP_W-1:0]    temp;
  } tick_t;

  // same order as the result beat, lowest field last
  typedef struct packed {
    logic [HPM_W-1:0]   avg;
    logic               run;
    logic [FAULT_W-1:0] fault;
    logic [DELAY_W-1:0] delay;
    logic               write;
    logic [VOLT_W-1:0]  req;
  } feedback_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 wr_en = 1'b0;
  logic [REG_IDX_W-1:0] wr_addr = '0;
  logic [VOLT_W-1:0]    wr_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [TICK_W-1:0]    s_tdata = '0;
  logic [STATUS_W-1:0]  s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [FB_W-1:0]      m_tdata;

  avs_voltage_feedback_step u_top (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // shadow of the block's registers and loop state
  logic [TARGET_W-1:0] cfg_target = '0;
  logic [VOLT_W-1:0]   cfg_min    = MIN_VOLT_RESET;
  logic [VOLT_W-1:0]   cfg_safe   = SAFE_VOLT_RESET;
  logic                loop_on    = 1'b0;

  tick_t     tick_queue[$];
  feedback_t expected_feedback[$];
  tick_t     cur_tick;
  feedback_t exp_fb;
  feedback_t got_fb;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int stalled_cycles = 0;
  int hold_left      = 0;
  logic long_stall_arm  = 1'b0;
  logic long_stall_done = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic feedback_t trip_loop(logic [FAULT_W-1:0] code);
    feedback_t r;
    r = '0;
    loop_on = 1'b0;
    r.req   = cfg_safe;
    r.write = 1'b1;
    r.delay = STOP_DELAY_MS;
    r.fault = code;
    return r;
  endfunction

  function automatic feedback_t predict_feedback(tick_t t);
    feedback_t r;
    int sum;
    int avg;
    int v;
    int nxt;
    r = '0;
    r.req   = t.volt;
    r.delay = STOP_DELAY_MS;
    r.fault = FLT_NONE;
    if (!loop_on) return r;
    r.run = 1'b1;
    if (t.status == ST_ABSENT) begin
      r.delay = IDLE_DELAY_MS;
      return r;
    end
    if (t.status != ST_VALID) return trip_loop(FLT_READ_ERR);
    if (int'(t.temp) >= int'(MAX_TEMP_MC)) return trip_loop(FLT_OVER_TEMP);
    v = int'(t.volt);
    if (v < int'(cfg_min) || v > int'(cfg_safe)) return trip_loop(FLT_WINDOW);
    sum = 0;
    for (int i = 0; i < HPM_N; i++) sum += int'(t.hpm[i]);
    avg = sum / HPM_N;
    if (avg == 0) return trip_loop(FLT_ZERO_AVG);
    nxt = v;
    r.delay = STEP_DELAY_MS;
    if (avg <= int'(cfg_target) + HOLD_LOW_MARGIN) begin
      nxt = v + int'(STEP_UV);
      if (nxt > int'(cfg_safe)) nxt = int'(cfg_safe);
    end else if (avg >= int'(cfg_target) + HOLD_HIGH_MARGIN) begin
      nxt = (v >= int'(STEP_UV)) ? v - int'(STEP_UV) : 0;
      if (nxt < int'(cfg_min)) nxt = int'(cfg_min);
    end else begin
      r.delay = IDLE_DELAY_MS;
    end
    r.req   = VOLT_W'(nxt);
    r.write = (nxt != v);
    r.avg   = HPM_W'(avg);
    return r;
  endfunction

  function automatic tick_t mk_tick(logic [STATUS_W-1:0] st, int temp_mc, int volt_uv,
                                    int hpm_val);
    tick_t t;
    t.status = st;
    t.temp   = TEMP_W'(temp_mc);
    t.volt   = VOLT_W'(volt_uv);
    for (int i = 0; i < HPM_N; i++) t.hpm[i] = HPM_W'(hpm_val);
    return t;
  endfunction

  // mostly healthy ticks near the current target; a few percent break the loop
  function automatic tick_t rand_tick();
    tick_t t;
    int pick;
    int lo;
    int hi;
    int v;
    int base;
    int s;
    pick = $urandom_range(999);
    lo = int'(cfg_min);
    hi = int'(cfg_safe);
    t.status = ST_VALID;
    t.temp   = TEMP_W'(int'($urandom_range(134999)) - 40000);
    if (lo <= hi) begin
      case ($urandom_range(3))
        0: begin
          v = lo + int'($urandom_range(15000));
          if (v > hi) v = hi;
        end
        1: begin
          v = hi - int'($urandom_range(15000));
          if (v < lo) v = lo;
        end
        default: v = int'($urandom_range(hi, lo));
      endcase
    end else begin
      v = int'($urandom_range(2000000));
    end
    t.volt = VOLT_W'(v);
    if ($urandom_range(4) == 0) begin
      for (int i = 0; i < HPM_N; i++) t.hpm[i] = HPM_W'($urandom_range(1023));
    end else begin
      base = int'(cfg_target) + int'($urandom_range(14)) - 3;
      if (base < 1) base = 1;
      if (base > 1023) base = 1023;
      for (int i = 0; i < HPM_N; i++) begin
        s = base + int'($urandom_range(6)) - 3;
        if (s < 0) s = 0;
        if (s > 1023) s = 1023;
        t.hpm[i] = HPM_W'(s);
      end
    end
    if (pick < 20) t.status = ST_ABSENT;
    else if (pick < 28) t.status = ($urandom_range(1) != 0) ? ST_UNKNOWN : ST_READ_ERR;
    else if (pick < 36) t.temp = TEMP_W'(95000 + int'($urandom_range(55000)));
    else if (pick < 44) t.volt = VOLT_W'($urandom_range(2000000));
    else if (pick < 52) begin
      for (int i = 0; i < HPM_N; i++) t.hpm[i] = HPM_W'($urandom_range(1));
    end
    return t;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
    end
  endfunction

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    wr_en   <= 1'b1;
    wr_addr <= idx;
    wr_data <= VOLT_W'(val);
    case (idx)
      REG_PERF_TARGET: cfg_target = TARGET_W'(val);
      REG_MIN_VOLT:    cfg_min    = VOLT_W'(val);
      REG_SAFE_VOLT:   cfg_safe   = VOLT_W'(val);
      REG_LOOP_ARM:    loop_on    = val[0];
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic wait_idle();
    while (tick_queue.size() != 0 || s_tvalid || expected_feedback.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic rearm_and_send(tick_t t);
    write_reg(REG_LOOP_ARM, 1);
    tick_queue.push_back(t);
    wait_idle();
  endtask

  // driver: tick predicted on the edge it is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= '0;
    end else begin
      if (s_tvalid && s_tready) expected_feedback.push_back(predict_feedback(cur_tick));
      if (!s_tvalid || s_tready) begin
        if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_tick = tick_queue.pop_front();
          s_tdata  <= TICK_W'({cur_tick.hpm, cur_tick.volt, cur_tick.temp});
          s_tuser  <= cur_tick.status;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver throttle
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_feedback.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", m_tdata);
        end else begin
          exp_fb = expected_feedback.pop_front();
          got_fb = m_tdata[FB_BITS-1:0];
          check_field("voltage_request_uv", exp_fb.req, got_fb.req);
          check_field("write_voltage", exp_fb.write, got_fb.write);
          check_field("next_delay_ms", exp_fb.delay, got_fb.delay);
          check_field("fault_code", exp_fb.fault, got_fb.fault);
          check_field("loop_running", exp_fb.run, got_fb.run);
          check_field("hpm_average", exp_fb.avg, got_fb.avg);
          check_field("tdata padding", 0, m_tdata[FB_W-1:FB_BITS]);
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stalled_cycles = 0;
      else stalled_cycles++;
      if (long_stall_arm && !long_stall_done) begin
        hold_left = LONG_HOLD;
        long_stall_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && stalled_cycles >= WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    tick_t t;
    int tgt;
    int lo;
    int hi;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // loop never armed
    tick_queue.push_back(mk_tick(ST_VALID, 150000, 2000000, 1023));
    wait_idle();

    write_reg(REG_PERF_TARGET, 100);
    write_reg(REG_LOOP_ARM, 1);
    tick_queue.push_back(mk_tick(ST_ABSENT, 25000, 1000000, 100));
    tick_queue.push_back(mk_tick(ST_VALID, -40000, 1000000, 100));
    tick_queue.push_back(mk_tick(ST_VALID, 94999, 1300000, 101));
    tick_queue.push_back(mk_tick(ST_VALID, 30000, 800000, 110));
    tick_queue.push_back(mk_tick(ST_VALID, 30000, 1000000, 110));
    tick_queue.push_back(mk_tick(ST_VALID, 30000, 1000000, 102));
    tick_queue.push_back(mk_tick(ST_VALID, 30000, 1000000, 109));
    t = mk_tick(ST_VALID, -1, 1048576, 0);
    for (int i = 0; i < HPM_N; i += 2) t.hpm[i] = 10'h3FF;
    tick_queue.push_back(t);
    tick_queue.push_back(mk_tick(ST_UNKNOWN, 30000, 1000000, 100));
    tick_queue.push_back(mk_tick(ST_VALID, 30000, 1000000, 100));
    wait_idle();

    // each fault stops the loop, so re-arm in between
    rearm_and_send(mk_tick(ST_READ_ERR, 30000, 1000000, 100));
    rearm_and_send(mk_tick(ST_VALID, 95000, 1000000, 100));
    rearm_and_send(mk_tick(ST_VALID, 30000, 799999, 100));
    rearm_and_send(mk_tick(ST_VALID, 30000, 1300001, 100));
    rearm_and_send(mk_tick(ST_VALID, 30000, 1000000, 0));
    t = mk_tick(ST_VALID, 30000, 1000000, 0);
    t.hpm[3] = 10'd7;
    rearm_and_send(t);

    // step below zero saturates
    write_reg(REG_MIN_VOLT, 0);
    write_reg(REG_PERF_TARGET, 0);
    write_reg(REG_LOOP_ARM, 1);
    tick_queue.push_back(mk_tick(ST_VALID, 0, 5000, 1023));
    tick_queue.push_back(mk_tick(ST_VALID, 0, 0, 1023));
    tick_queue.push_back(mk_tick(ST_VALID, 0, 0, 1));
    wait_idle();

    // empty window
    write_reg(REG_MIN_VOLT, 1000000);
    write_reg(REG_SAFE_VOLT, 900000);
    rearm_and_send(mk_tick(ST_VALID, 0, 950000, 500));

    write_reg(REG_PERF_TARGET, 1017);
    write_reg(REG_MIN_VOLT, 800000);
    write_reg(REG_SAFE_VOLT, 2000000);
    write_reg(REG_LOOP_ARM, 1);
    tick_queue.push_back(mk_tick(ST_VALID, 0, 2000000, 1023));
    tick_queue.push_back(mk_tick(ST_VALID, 0, 1995000, 1010));
    wait_idle();
    write_reg(REG_LOOP_ARM, 0);
    tick_queue.push_back(mk_tick(ST_VALID, 0, 1000000, 500));
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      if (p % 8 == 0) tgt = 0;
      else if (p % 8 == 1) tgt = 1017;
      else tgt = $urandom_range(1017);
      case ($urandom_range(9))
        0: begin lo = 0; hi = 2000000; end
        1: begin lo = 1000000; hi = 900000; end
        2: begin lo = $urandom_range(1400000, 600000); hi = lo; end
        default: begin
          lo = $urandom_range(1000000, 500000);
          hi = $urandom_range(1500000, 1000000);
        end
      endcase
      write_reg(REG_PERF_TARGET, tgt);
      write_reg(REG_MIN_VOLT, lo);
      write_reg(REG_SAFE_VOLT, hi);
      write_reg(REG_LOOP_ARM, (p % 9 == 4) ? 0 : 1);
      if (p == 8) long_stall_arm = 1'b1;
      repeat (PHASE_TICKS) tick_queue.push_back(rand_tick());
      wait_idle();
    end

    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
